@@ hw/rtl/mocmp_pkg.sv @@
`timescale 1ns / 1ps
package mocmp_pkg;

    localparam int MAX_TERM_LEN = 16;
    localparam int RANK_BITS    = 8;
    localparam int EXP_BITS     = 16;

    localparam int LEN_W  = $clog2(MAX_TERM_LEN + 1);
    localparam int ADDR_W = (MAX_TERM_LEN > 1) ? $clog2(MAX_TERM_LEN) : 1;
    localparam int PAIR_W = RANK_BITS + EXP_BITS;
    localparam int SUM_W  = EXP_BITS + LEN_W;
    localparam int CMP_W  = (SUM_W > RANK_BITS) ? SUM_W : RANK_BITS;

    typedef logic [RANK_BITS-1:0] t_rank;
    typedef logic [EXP_BITS-1:0]  t_exp;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [PAIR_W-1:0]    t_pair;
    typedef logic [CMP_W-1:0]     t_cmp;
    typedef logic [1:0]           t_mode;
    typedef logic [1:0]           t_cmd;
    typedef logic [1:0]           t_status;

    localparam t_mode MODE_LEX       = 2'd0;
    localparam t_mode MODE_GRLEX     = 2'd1;
    localparam t_mode MODE_DEGREVLEX = 2'd2;

    localparam t_cmd CMD_APPEND_A = 2'd0;
    localparam t_cmd CMD_APPEND_B = 2'd1;
    localparam t_cmd CMD_COMPARE  = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_MISMATCH = 2'd2;

    typedef enum logic [1:0] {
        ORD_LT = 2'd0,
        ORD_EQ = 2'd1,
        ORD_GT = 2'd2
    } t_ord;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STRIP_RD,
        S_STRIP_EV,
        S_DEGREE,
        S_WALK_RD,
        S_WALK_RANK,
        S_WALK_EXP,
        S_LENGTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic  start;
        t_rank thr;
        t_mode mode;
    } t_seq_req;

    typedef struct packed {
        logic done;
        t_ord order;
        logic mismatch;
    } t_seq_rsp;

endpackage

@@ hw/rtl/mocmp_ram.sv @@
`timescale 1ns / 1ps
module mocmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mocmp_cmp.sv @@
`timescale 1ns / 1ps
module mocmp_cmp
    import mocmp_pkg::*;
(
    input  t_cmp i_a,
    input  t_cmp i_b,
    output t_ord o_res
);

    always_comb begin
        if (i_a < i_b) begin
            o_res = ORD_LT;
        end else if (i_a > i_b) begin
            o_res = ORD_GT;
        end else begin
            o_res = ORD_EQ;
        end
    end

endmodule

@@ hw/rtl/mocmp_seq.sv @@
`timescale 1ns / 1ps
module mocmp_seq
    import mocmp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seq_req i_req,
    input  t_len     i_len_a,
    input  t_len     i_len_b,
    input  t_pair    i_rdata_a,
    input  t_pair    i_rdata_b,
    input  logic     i_out_free,
    output t_addr    o_raddr_a,
    output t_addr    o_raddr_b,
    output t_seq_rsp o_rsp
);

    t_state r_state, n_state;
    t_rank  r_thr, n_thr;
    t_mode  r_mode, n_mode;
    t_len   r_k, n_k;
    logic   r_a_live, n_a_live;
    logic   r_b_live, n_b_live;
    t_len   r_la, n_la;
    t_len   r_lb, n_lb;
    t_sum   r_sum_a, n_sum_a;
    t_sum   r_sum_b, n_sum_b;
    t_ord   r_order, n_order;
    logic   r_mism, n_mism;

    t_rank rank_a, rank_b;
    t_exp  exp_a, exp_b;
    t_cmp  cmp_a, cmp_b;
    t_ord  cmp_res;
    logic  a_ok, b_ok;
    logic  is_lex, is_rev;
    t_len  min_len, tail_a, tail_b;

    assign rank_a = i_rdata_a[PAIR_W-1 -: RANK_BITS];
    assign exp_a  = i_rdata_a[EXP_BITS-1:0];
    assign rank_b = i_rdata_b[PAIR_W-1 -: RANK_BITS];
    assign exp_b  = i_rdata_b[EXP_BITS-1:0];

    // unused mode code falls back to lex
    assign is_rev = (r_mode == MODE_DEGREVLEX);
    assign is_lex = (r_mode != MODE_GRLEX) && !is_rev;

    assign min_len = (r_la < r_lb) ? r_la : r_lb;
    assign tail_a  = r_la - t_len'(1) - r_k;
    assign tail_b  = r_lb - t_len'(1) - r_k;

    // degrevlex walks from the tails during the pair walk
    always_comb begin
        if (is_rev && (r_state == S_WALK_RD || r_state == S_WALK_RANK
                       || r_state == S_WALK_EXP)) begin
            o_raddr_a = tail_a[ADDR_W-1:0];
            o_raddr_b = tail_b[ADDR_W-1:0];
        end else begin
            o_raddr_a = r_k[ADDR_W-1:0];
            o_raddr_b = r_k[ADDR_W-1:0];
        end
    end

    assign a_ok = r_a_live && (r_k < i_len_a) && (rank_a >= r_thr);
    assign b_ok = r_b_live && (r_k < i_len_b) && (rank_b >= r_thr);

    mocmp_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_thr    <= n_thr;
        r_mode   <= n_mode;
        r_k      <= n_k;
        r_a_live <= n_a_live;
        r_b_live <= n_b_live;
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_sum_a  <= n_sum_a;
        r_sum_b  <= n_sum_b;
        r_order  <= n_order;
        r_mism   <= n_mism;
    end

    always_comb begin
        n_state  = r_state;
        n_thr    = r_thr;
        n_mode   = r_mode;
        n_k      = r_k;
        n_a_live = r_a_live;
        n_b_live = r_b_live;
        n_la     = r_la;
        n_lb     = r_lb;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_order  = r_order;
        n_mism   = r_mism;
        cmp_a    = t_cmp'(r_sum_a);
        cmp_b    = t_cmp'(r_sum_b);
        o_rsp    = '{done: 1'b0, order: r_order, mismatch: r_mism};

        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_thr    = i_req.thr;
                    n_mode   = i_req.mode;
                    n_k      = '0;
                    n_a_live = 1'b1;
                    n_b_live = 1'b1;
                    n_sum_a  = '0;
                    n_sum_b  = '0;
                    n_mism   = 1'b0;
                    n_state  = S_STRIP_RD;
                end
            end
            S_STRIP_RD: begin
                n_state = S_STRIP_EV;
            end
            S_STRIP_EV: begin
                // cut each term at its first pair ranked below threshold
                if (r_a_live) begin
                    if (a_ok) begin
                        n_sum_a = r_sum_a + t_sum'(exp_a);
                    end else begin
                        n_la     = r_k;
                        n_a_live = 1'b0;
                    end
                end
                if (r_b_live) begin
                    if (b_ok) begin
                        n_sum_b = r_sum_b + t_sum'(exp_b);
                    end else begin
                        n_lb     = r_k;
                        n_b_live = 1'b0;
                    end
                end
                if (a_ok || b_ok) begin
                    n_k     = r_k + t_len'(1);
                    n_state = S_STRIP_RD;
                end else if (is_lex) begin
                    n_k     = '0;
                    n_state = S_WALK_RD;
                end else begin
                    n_state = S_DEGREE;
                end
            end
            S_DEGREE: begin
                cmp_a = t_cmp'(r_sum_a);
                cmp_b = t_cmp'(r_sum_b);
                if (cmp_res != ORD_EQ) begin
                    n_order = cmp_res;
                    n_state = S_DONE;
                end else begin
                    n_k     = '0;
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (r_k == min_len) begin
                    n_state = S_LENGTH;
                end else begin
                    n_state = S_WALK_RANK;
                end
            end
            S_WALK_RANK: begin
                cmp_a = t_cmp'(rank_a);
                cmp_b = t_cmp'(rank_b);
                if (cmp_res != ORD_EQ) begin
                    n_order = cmp_res;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK_EXP;
                end
            end
            S_WALK_EXP: begin
                // degrevlex: larger exponent on a tied rank is less
                if (is_rev) begin
                    cmp_a = t_cmp'(exp_b);
                    cmp_b = t_cmp'(exp_a);
                end else begin
                    cmp_a = t_cmp'(exp_a);
                    cmp_b = t_cmp'(exp_b);
                end
                if (cmp_res != ORD_EQ) begin
                    n_order = cmp_res;
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + t_len'(1);
                    n_state = S_WALK_RD;
                end
            end
            S_LENGTH: begin
                cmp_a = t_cmp'(r_la);
                cmp_b = t_cmp'(r_lb);
                if (is_rev) begin
                    n_order = ORD_EQ;
                    n_mism  = (cmp_res != ORD_EQ);
                end else begin
                    n_order = cmp_res;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_rsp.done = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/monomial_order_compare.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_cmd, i_var_rank, i_exponent,
//                                                 i_strip_threshold
// output    out        o_out_valid / i_out_stall  o_order, o_status
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_ordering_mode
//
// An append request is taken whenever the block is not busy. A compare request
// keeps the input stalled while the sequencer walks the term stores through one
// shared comparator: a strip/degree pass over the kept prefixes, the degree check
// outside lex mode, a pair walk over the common pairs, and then the finish.
// Reset (i_rst_n low, synchronous) clears lengths, overflow flag, mode and
// handshake state; store contents stay undefined and are never read unwritten.
// A held result in the output register stalls only the next compare's finish.
module monomial_order_compare
    import mocmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_var_rank,
    input  logic [15:0] i_exponent,
    input  logic [7:0] i_strip_threshold,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_order,
    output logic [1:0] o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_ordering_mode
);

    logic    r_busy, n_busy;
    t_mode   r_mode;
    t_len    r_len_a, n_len_a;
    t_len    r_len_b, n_len_b;
    logic    r_ovf, n_ovf;
    logic    r_out_valid, n_out_valid;
    t_ord    r_order, n_order;
    t_status r_status, n_status;

    logic     in_acc;
    logic     out_free;
    logic     we_a, we_b;
    t_pair    wdata;
    t_addr    raddr_a, raddr_b;
    t_pair    rdata_a, rdata_b;
    t_seq_req req;
    t_seq_rsp rsp;

    assign in_acc   = i_in_valid && !r_busy;
    // output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_order     = r_order;
    assign o_status    = r_status;

    assign wdata = {t_rank'(i_var_rank), t_exp'(i_exponent)};

    // stores are full when the length reaches capacity; such appends drop
    assign we_a = in_acc && (i_cmd == CMD_APPEND_A)
                  && (r_len_a < t_len'(MAX_TERM_LEN));
    assign we_b = in_acc && (i_cmd == CMD_APPEND_B)
                  && (r_len_b < t_len'(MAX_TERM_LEN));

    assign req = '{start: in_acc && (i_cmd == CMD_COMPARE),
                   thr:   t_rank'(i_strip_threshold),
                   mode:  r_mode};

    mocmp_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_TERM_LEN)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_len_a[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mocmp_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_TERM_LEN)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_len_b[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    mocmp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_len_a    (r_len_a),
        .i_len_b    (r_len_b),
        .i_rdata_a  (rdata_a),
        .i_rdata_b  (rdata_b),
        .i_out_free (out_free),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b),
        .o_rsp      (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mode      <= MODE_LEX;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_len_a     <= n_len_a;
            r_len_b     <= n_len_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_ordering_mode;
            end
        end
        r_order  <= n_order;
        r_status <= n_status;
    end

    always_comb begin
        n_busy      = r_busy;
        n_len_a     = r_len_a;
        n_len_b     = r_len_b;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_order     = r_order;
        n_status    = r_status;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (in_acc) begin
            case (i_cmd)
                CMD_APPEND_A: begin
                    if (we_a) begin
                        n_len_a = r_len_a + t_len'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                CMD_APPEND_B: begin
                    if (we_b) begin
                        n_len_b = r_len_b + t_len'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                CMD_COMPARE: begin
                    n_busy = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // compare finished and the output register is free: publish, clear
        if (rsp.done && out_free) begin
            n_out_valid = 1'b1;
            n_order     = rsp.order;
            n_status    = r_ovf ? ST_OVERFLOW : (rsp.mismatch ? ST_MISMATCH : ST_OK);
            n_len_a     = '0;
            n_len_b     = '0;
            n_ovf       = 1'b0;
            n_busy      = 1'b0;
        end
    end

endmodule

@@ sim/monomial_order_compare_tb.sv @@
`timescale 1ns / 1ps
module monomial_order_compare_tb;
    import mocmp_pkg::*;

    // Codes the package leaves unnamed: the fourth command and the fourth mode.
    localparam t_cmd  CMD_UNUSED  = 2'd3;
    localparam t_mode MODE_UNUSED = 2'd3;

    localparam int SLOT_DEPTH     = 20;    // room for terms longer than a store
    localparam int SEG_REQUESTS   = 135;   // requests per random segment
    localparam int SETTLE_CYCLES  = 8;     // lets a trailing append settle
    localparam int TAIL_CYCLES    = 120;   // longer than a full compare walk
    localparam int LONG_HOLD      = 400;   // result side hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake

    // Expected order/status for each compare, in request order, from a
    // private copy of both term stores, the overflow flag and the mode.
    class order_scoreboard;
        t_mode       mode = MODE_LEX;
        t_rank       rank_st[2][MAX_TERM_LEN];
        t_exp        exp_st[2][MAX_TERM_LEN];
        int unsigned len_st[2] = '{0, 0};
        bit          overflow = 1'b0;
        t_ord        want_order[$];
        t_status     want_status[$];
        int unsigned failures = 0;
        int unsigned reported = 0;
        int unsigned requests = 0;
        int unsigned results = 0;
        int unsigned per_mode[4] = '{0, 0, 0, 0};
        int unsigned overflow_cnt = 0;
        int unsigned length_cnt = 0;

        function void set_mode(t_mode m);
            mode = m;
        endfunction

        function int unsigned pending();
            return want_order.size();
        endfunction

        function void fail(string msg);
            failures++;
            if (reported < 10) begin
                reported++;
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        function t_ord order_by_value(longint unsigned x, longint unsigned y);
            if (x < y) return ORD_LT;
            if (x > y) return ORD_GT;
            return ORD_EQ;
        endfunction

        // A term is cut at its first pair ranked below the threshold.
        function int unsigned kept_len(int t, t_rank thr);
            int unsigned n;
            n = 0;
            while (n < len_st[t] && rank_st[t][n] >= thr) n++;
            return n;
        endfunction

        function longint unsigned degree(int t, int unsigned n);
            longint unsigned s;
            s = 0;
            for (int unsigned i = 0; i < n; i++) s += exp_st[t][i];
            return s;
        endfunction

        function t_ord lex_order(int unsigned la, int unsigned lb);
            int unsigned m;
            m = (la < lb) ? la : lb;
            for (int unsigned i = 0; i < m; i++) begin
                if (rank_st[0][i] != rank_st[1][i])
                    return order_by_value(rank_st[0][i], rank_st[1][i]);
                if (exp_st[0][i] != exp_st[1][i])
                    return order_by_value(exp_st[0][i], exp_st[1][i]);
            end
            return order_by_value(la, lb);
        endfunction

        // Walk from both tails; equal ranks compare exponents reversed.
        function t_ord tail_order(int unsigned la, int unsigned lb, output bit leftover);
            int unsigned i;
            int unsigned j;
            i = la;
            j = lb;
            leftover = 1'b0;
            while (i > 0 && j > 0) begin
                if (rank_st[0][i-1] != rank_st[1][j-1])
                    return order_by_value(rank_st[0][i-1], rank_st[1][j-1]);
                if (exp_st[0][i-1] != exp_st[1][j-1])
                    return order_by_value(exp_st[1][j-1], exp_st[0][i-1]);
                i--;
                j--;
            end
            leftover = (i > 0 || j > 0);
            return ORD_EQ;
        endfunction

        function void predict_order(t_rank thr);
            int unsigned la;
            int unsigned lb;
            bit          leftover;
            t_ord        o;
            t_status     s;
            la = kept_len(0, thr);
            lb = kept_len(1, thr);
            leftover = 1'b0;
            if (mode == MODE_GRLEX || mode == MODE_DEGREVLEX) begin
                o = order_by_value(degree(0, la), degree(1, lb));
                if (o == ORD_EQ)
                    o = (mode == MODE_GRLEX) ? lex_order(la, lb) : tail_order(la, lb, leftover);
            end else begin
                o = lex_order(la, lb);
            end
            s = overflow ? ST_OVERFLOW : (leftover ? ST_MISMATCH : ST_OK);
            if (s == ST_OVERFLOW) overflow_cnt++;
            if (s == ST_MISMATCH) length_cnt++;
            per_mode[mode]++;
            want_order.push_back(o);
            want_status.push_back(s);
            len_st = '{0, 0};
            overflow = 1'b0;
        endfunction

        function void note_request(t_cmd cmd, t_rank rank, t_exp e, t_rank thr);
            int t;
            requests++;
            case (cmd)
                CMD_APPEND_A, CMD_APPEND_B: begin
                    t = (cmd == CMD_APPEND_B) ? 1 : 0;
                    if (len_st[t] < MAX_TERM_LEN) begin
                        rank_st[t][len_st[t]] = rank;
                        exp_st[t][len_st[t]] = e;
                        len_st[t]++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                CMD_COMPARE: predict_order(thr);
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] got_order, logic [1:0] got_status);
            t_ord    o;
            t_status s;
            results++;
            if (want_order.size() == 0) begin
                fail($sformatf("result order=%0d status=%0d with no compare pending",
                               got_order, got_status));
                return;
            end
            o = want_order.pop_front();
            s = want_status.pop_front();
            if (got_order !== o)
                fail($sformatf("result %0d order: expected %0d, got %0d", results, o, got_order));
            if (got_status !== s)
                fail($sformatf("result %0d status: expected %0d, got %0d", results, s,
                               got_status));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = CMD_UNUSED;
    logic [7:0]  i_var_rank = '0;
    logic [15:0] i_exponent = '0;
    logic [7:0]  i_strip_threshold = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_order;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_ordering_mode = MODE_LEX;

    order_scoreboard sb = new;

    int          src_idle_pct = 0;    // chance per cycle that no request is offered
    int          sink_idle_pct = 0;   // chance per cycle that results are held off
    int          hold_cycles = 0;     // pending long hold-off on the result side
    int unsigned items_sent = 0;      // requests that count toward the budget
    int unsigned quiet_cycles = 0;

    // Scratch terms built by the stimulus before they are sent.
    t_rank       term_rk[2][SLOT_DEPTH];
    t_exp        term_ex[2][SLOT_DEPTH];
    int unsigned term_len[2];

    monomial_order_compare DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_var_rank         (i_var_rank),
        .i_exponent         (i_exponent),
        .i_strip_threshold  (i_strip_threshold),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_order            (o_order),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_ordering_mode(i_cfg_ordering_mode)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result-side stall, changed at the falling edge. A long hold-off
    // requested by the stimulus takes priority over the random one.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // Every handshake is observed at the rising edge, before the block's
    // registers move. The watchdog counts edges with no handshake at all.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_mode(i_cfg_ordering_mode);
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_cmd, i_var_rank, i_exponent, i_strip_threshold);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_order, o_status);
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, sb.pending());
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offers one request, entered and left at a falling edge. Valid stays
    // high into the next request unless the sender idles.
    task automatic send_req(input t_cmd cmd, input t_rank rank, input t_exp e,
                            input t_rank thr);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_cmd             <= cmd;
        i_var_rank        <= rank;
        i_exponent        <= e;
        i_strip_threshold <= thr;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic append(input int t, input t_rank rank, input t_exp e);
        send_req(t ? CMD_APPEND_B : CMD_APPEND_A, rank, e, t_rank'($urandom));
    endtask

    task automatic compare(input t_rank thr);
        send_req(CMD_COMPARE, t_rank'($urandom), t_exp'($urandom), thr);
    endtask

    // Sender pauses until every expected result is back, then lets a
    // trailing append settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        i_cfg_valid         <= 1'b1;
        i_cfg_ordering_mode <= m;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_exp pick_exp();
        case ($urandom_range(9))
            0:       return '1;
            1, 2:    return t_exp'($urandom);
            default: return t_exp'($urandom_range(6));
        endcase
    endfunction

    // Mostly short terms; a few fill the store, a few overflow it.
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(4);
        if (r < 85) return $urandom_range(10, 5);
        if (r < 96) return $urandom_range(MAX_TERM_LEN, 11);
        return $urandom_range(MAX_TERM_LEN + 2, MAX_TERM_LEN + 1);
    endfunction

    // Well-formed terms have distinct ranks in decreasing order.
    function automatic void fresh_term(input int t, input int unsigned len, input bit unsorted);
        int prev;
        int r;
        prev = 256;
        term_len[t] = len;
        for (int i = 0; i < int'(len); i++) begin
            if (unsorted) begin
                r = $urandom_range(255);
            end else begin
                r = $urandom_range(prev - 1, int'(len) - 1 - i);
                prev = r;
            end
            term_rk[t][i] = t_rank'(r);
            term_ex[t][i] = pick_exp();
        end
    endfunction

    // Second term as a near copy of the first, so the compare walks deep:
    // degree-preserving moves, a dropped tail, a zero-degree head pair.
    function automatic void derive_term();
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned k;
        n = term_len[0];
        term_rk[1] = term_rk[0];
        term_ex[1] = term_ex[0];
        term_len[1] = n;
        i = (n > 0) ? $urandom_range(n - 1) : 0;
        case ($urandom_range(7))
            1: if (n > 0) term_ex[1][i] = pick_exp();
            2: if (n >= 2) begin
                i = $urandom_range(n - 2);
                j = $urandom_range(n - 1, i + 1);
                if ($urandom_range(1)) begin
                    k = i; i = j; j = k;
                end
                k = $urandom_range(term_ex[1][i]);
                if (int'(term_ex[1][j]) + k <= 65535) begin
                    term_ex[1][i] = term_ex[1][i] - t_exp'(k);
                    term_ex[1][j] = term_ex[1][j] + t_exp'(k);
                end
            end
            3: if (n > 0) term_len[1] = n - 1;
            4: if (n < SLOT_DEPTH - 1 && (n == 0 || term_rk[0][0] != 8'hFF)) begin
                for (int m = n; m > 0; m--) begin
                    term_rk[1][m] = term_rk[0][m-1];
                    term_ex[1][m] = term_ex[0][m-1];
                end
                term_rk[1][0] = (n == 0) ? t_rank'($urandom)
                                : t_rank'($urandom_range(255, term_rk[0][0] + 1));
                term_ex[1][0] = '0;
                term_len[1] = n + 1;
            end
            5: if (n > 0) term_rk[1][i] = t_rank'($urandom);
            6: fresh_term(1, pick_len(), 1'b0);
            7: if (n < SLOT_DEPTH && n > 0 && term_rk[0][n-1] != 8'h00) begin
                term_rk[1][n] = t_rank'($urandom_range(term_rk[0][n-1] - 1));
                term_ex[1][n] = pick_exp();
                term_len[1] = n + 1;
            end
            default: ;
        endcase
    endfunction

    function automatic t_rank pick_threshold();
        int unsigned r;
        int          t;
        r = $urandom_range(99);
        t = $urandom_range(1);
        if (r < 55) return '0;
        if (r < 75 || term_len[t] == 0) return t_rank'($urandom);
        r = term_rk[t][$urandom_range(term_len[t] - 1)] + $urandom_range(1);
        return (r > 255) ? 8'hFF : t_rank'(r);
    endfunction

    // One pair of terms and the compare that consumes them. About one in
    // seven is noise: unsorted ranks or two unrelated terms.
    task automatic run_sequence();
        bit          noise;
        int unsigned ia;
        int unsigned ib;
        t_rank       thr;
        t_rank       rk_tmp[SLOT_DEPTH];
        t_exp        ex_tmp[SLOT_DEPTH];
        int unsigned len_tmp;
        noise = ($urandom_range(99) < 15);
        fresh_term(0, pick_len(), noise);
        if (noise && $urandom_range(1))
            fresh_term(1, pick_len(), 1'b1);
        else
            derive_term();
        if ($urandom_range(1)) begin
            rk_tmp = term_rk[0]; ex_tmp = term_ex[0]; len_tmp = term_len[0];
            term_rk[0] = term_rk[1]; term_ex[0] = term_ex[1]; term_len[0] = term_len[1];
            term_rk[1] = rk_tmp; term_ex[1] = ex_tmp; term_len[1] = len_tmp;
        end
        thr = pick_threshold();
        ia = 0;
        ib = 0;
        // Appends to the two stores interleave at random; order within a
        // term is kept. The unused command is dropped in now and then.
        while (ia < term_len[0] || ib < term_len[1]) begin
            if ($urandom_range(99) < 4)
                send_req(CMD_UNUSED, t_rank'($urandom), t_exp'($urandom), t_rank'($urandom));
            if (ia < term_len[0] && (ib >= term_len[1] || $urandom_range(1))) begin
                append(0, term_rk[0][ia], term_ex[0][ia]);
                ia++;
            end else begin
                append(1, term_rk[1][ib], term_ex[1][ib]);
                ib++;
            end
        end
        compare(thr);
    endtask

    initial begin
        t_mode       seg_mode[4];
        int unsigned target;
        seg_mode = '{MODE_LEX, MODE_GRLEX, MODE_DEGREVLEX, MODE_UNUSED};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, lex: empty terms, a prefix with extreme fields, a
        // threshold that strips one term away, the unused command, rank win.
        write_mode(MODE_LEX);
        compare(8'h00);
        append(0, 8'hFF, 16'hFFFF);
        append(0, 8'h00, 16'h0000);
        append(1, 8'hFF, 16'hFFFF);
        compare(8'h00);
        append(0, 8'hFF, 16'h0001);
        append(0, 8'hFE, 16'h0005);
        append(1, 8'h00, 16'hFFFF);
        compare(8'hFF);
        send_req(CMD_UNUSED, 8'hA5, 16'h5A5A, 8'h3C);
        append(1, 8'h08, 16'h0000);
        append(0, 8'h06, 16'h0001);
        compare(8'h00);
        drain();

        // Directed, degrevlex: equal tails with a zero-degree pair left over,
        // and unsorted input where the strip cut hides a later high rank.
        write_mode(MODE_DEGREVLEX);
        append(0, 8'h09, 16'h0000);
        append(0, 8'h04, 16'h0003);
        append(1, 8'h04, 16'h0003);
        compare(8'h00);
        append(0, 8'h03, 16'h0001);
        append(0, 8'h09, 16'h0002);
        append(1, 8'h03, 16'h0001);
        compare(8'h05);
        drain();

        // Random part: three idling phases, each through all four modes.
        for (int seg = 0; seg < 12; seg++) begin
            case (seg / 4)
                0:       begin src_idle_pct = 23; sink_idle_pct = 53; end
                1:       begin src_idle_pct = 53; sink_idle_pct = 23; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            write_mode(seg_mode[seg % 4]);
            // Results held off while requests keep coming, so the output
            // register fills and the input backs up.
            if (seg == 1) hold_cycles = LONG_HOLD;
            target = items_sent + SEG_REQUESTS;
            while (items_sent < target) run_sequence();
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.fail($sformatf("%0d compare results never arrived", sb.pending()));

        $display("Sent %0d requests, checked %0d results (lex %0d, grlex %0d, degrevlex %0d,",
                 sb.requests, sb.results, sb.per_mode[MODE_LEX], sb.per_mode[MODE_GRLEX],
                 sb.per_mode[MODE_DEGREVLEX]);
        $display("unused mode %0d); overflow status %0d, length mismatch status %0d, %0d errors",
                 sb.per_mode[MODE_UNUSED], sb.overflow_cnt, sb.length_cnt, sb.failures);
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mocmp_pkg.sv
hw/rtl/mocmp_ram.sv
hw/rtl/mocmp_cmp.sv
hw/rtl/mocmp_seq.sv
hw/rtl/monomial_order_compare.sv
sim/monomial_order_compare_tb.sv
